FILE: design/edd_pkg.sv
package edd_pkg;

  // Largest supported row length and the line store that follows from it.
  localparam int unsigned MAX_WIDTH = 4096;
  localparam int unsigned LS_AW     = $clog2(MAX_WIDTH);
  localparam int unsigned LS_CW     = LS_AW + 1;

  // Field and state widths.
  localparam int unsigned SAMPLE_W = 18;
  localparam int unsigned ERR_W    = 13;
  localparam int unsigned COL_W    = 12;
  localparam int unsigned ROW_W    = 16;
  localparam int unsigned LWID_W   = 13;
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned X_W      = 24;
  localparam int unsigned Q_W      = 13;
  localparam int unsigned PROD_W   = 16;

  // Configuration port.
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_DITHER_ENABLE = 2'd0,
    REG_LINE_WIDTH    = 2'd1,
    REG_ROW_COUNT     = 2'd2
  } reg_idx_t;

  localparam logic [LWID_W-1:0] LINE_WIDTH_RST = LWID_W'(640);
  localparam logic [ROW_W-1:0]  ROW_COUNT_RST  = ROW_W'(480);

  typedef struct packed {
    logic              dither_enable;
    logic [LWID_W-1:0] line_width;
    logic [ROW_W-1:0]  row_count;
  } cfg_t;

  // One pixel held in the working stage.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [COL_W-1:0]           col;
    logic                       row_nz;
    logic                       last_col;
    logic                       last_row;
    logic                       dith;
  } pix_t;

  // Write request into the line store.
  typedef struct packed {
    logic                    we;
    logic [LS_AW-1:0]        addr;
    logic signed [ERR_W-1:0] data;
  } ls_wr_t;

  // k*e/16 rounded to the nearest 1/4096 level, halves towards plus infinity.
  function automatic logic signed [ERR_W-1:0] share16(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] t;
    t = v + PROD_W'(8);
    return ERR_W'(t >>> 4);
  endfunction

endpackage

FILE: design/edd_cfg_regs.sv
module edd_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [edd_pkg::PADDR_W-1:0]    cfg_paddr,
  input  logic [edd_pkg::PDATA_W-1:0]    cfg_pwdata,
  output logic [edd_pkg::PDATA_W-1:0]    cfg_prdata,
  output logic                           cfg_pready,
  output edd_pkg::cfg_t                  cfg
);
  import edd_pkg::*;

  logic     wr_en;
  reg_idx_t idx;
  cfg_t     cfg_r;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx        = reg_idx_t'(cfg_paddr[PADDR_W-1:2]);
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dither_enable <= 1'b0;
      cfg_r.line_width    <= LINE_WIDTH_RST;
      cfg_r.row_count     <= ROW_COUNT_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_DITHER_ENABLE: cfg_r.dither_enable <= cfg_pwdata[0];
        REG_LINE_WIDTH:    cfg_r.line_width    <= cfg_pwdata[LWID_W-1:0];
        REG_ROW_COUNT:     cfg_r.row_count     <= cfg_pwdata[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DITHER_ENABLE: cfg_prdata = PDATA_W'(cfg_r.dither_enable);
      REG_LINE_WIDTH:    cfg_prdata = PDATA_W'(cfg_r.line_width);
      REG_ROW_COUNT:     cfg_prdata = PDATA_W'(cfg_r.row_count);
      default:           cfg_prdata = '0;
    endcase
  end

endmodule

FILE: design/edd_line_store.sv
module edd_line_store (
  input  logic                              clk,
  input  logic                              rst_n,
  input  edd_pkg::ls_wr_t                   wr,
  input  logic                              rd_en,
  input  logic [edd_pkg::LS_AW-1:0]         rd_addr,
  output logic signed [edd_pkg::ERR_W-1:0]  rd_data,
  output logic                              clearing
);
  import edd_pkg::*;

  logic signed [ERR_W-1:0] mem [MAX_WIDTH];
  logic [LS_CW-1:0]        clr_cnt_r;
  logic signed [ERR_W-1:0] rd_data_r;
  logic signed [ERR_W-1:0] byp_data_r;
  logic                    byp_hit_r;
  logic                    we;
  logic [LS_AW-1:0]        waddr;
  logic signed [ERR_W-1:0] wdata;

  // The top bit of the sweep counter sets once every entry has been zeroed.
  assign clearing = !clr_cnt_r[LS_CW-1];

  always_comb begin
    if (clearing) begin
      we    = 1'b1;
      waddr = clr_cnt_r[LS_AW-1:0];
      wdata = '0;
    end else begin
      we    = wr.we;
      waddr = wr.addr;
      wdata = wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (clearing) begin
      clr_cnt_r <= clr_cnt_r + LS_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // A read that meets a write to the same entry at the same edge returns the new data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r  <= mem[rd_addr];
      byp_hit_r  <= we && (waddr == rd_addr);
      byp_data_r <= wdata;
    end
  end

  assign rd_data = byp_hit_r ? byp_data_r : rd_data_r;

endmodule

FILE: design/edd_core.sv
module edd_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  edd_pkg::pix_t                     pix,
  input  logic                              fire,
  input  logic signed [edd_pkg::ERR_W-1:0]  below,
  output logic [edd_pkg::LEVEL_W-1:0]       level,
  output logic                              frame_done,
  output edd_pkg::ls_wr_t                   wr
);
  import edd_pkg::*;

  logic signed [ERR_W-1:0]  right_carry_r;
  logic signed [ERR_W-1:0]  pend_near_r;
  logic signed [ERR_W-1:0]  pend_far_r;
  logic                     defer_v_r;
  logic [LS_AW-1:0]         defer_addr_r;
  logic signed [ERR_W-1:0]  defer_data_r;

  logic                     col_nz;
  logic signed [ERR_W-1:0]  below_eff;
  logic signed [ERR_W-1:0]  rc_eff;
  logic signed [ERR_W-1:0]  pn_eff;
  logic signed [ERR_W-1:0]  pf_eff;
  logic signed [ERR_W:0]    inc;
  logic signed [X_W-1:0]    x;
  logic [11:0]              frac;
  logic                     up;
  logic signed [Q_W-1:0]    q;
  logic signed [ERR_W-1:0]  e;
  logic signed [PROD_W-1:0] e_ext;
  logic                     diffuse;
  logic signed [ERR_W-1:0]  s1, s3, s5, s7;
  logic signed [ERR_W-1:0]  wr_now;
  logic signed [ERR_W-1:0]  near_nxt;

  assign col_nz    = (pix.col != '0);
  assign below_eff = (pix.dith && pix.row_nz) ? below : '0;
  assign rc_eff    = (pix.dith && col_nz) ? right_carry_r : '0;
  assign pn_eff    = col_nz ? pend_near_r : '0;
  assign pf_eff    = col_nz ? pend_far_r : '0;

  assign inc  = (ERR_W+1)'(below_eff) + (ERR_W+1)'(rc_eff);
  assign x    = (X_W'(pix.sample) <<< 4) + X_W'(inc);
  assign frac = x[11:0];
  // Round to nearest, ties to even.
  assign up   = (frac > 12'd2048) || ((frac == 12'd2048) && x[12]);
  assign q    = Q_W'($signed(x[X_W-1:12])) + Q_W'(up);
  assign e    = up ? (ERR_W'(frac) - ERR_W'(4096)) : ERR_W'(frac);

  assign e_ext   = PROD_W'(e);
  assign diffuse = pix.dith && !pix.last_row && col_nz && !pix.last_col;
  assign s1 = diffuse ? share16(e_ext) : '0;
  assign s3 = diffuse ? share16(e_ext * PROD_W'(3)) : '0;
  assign s5 = diffuse ? share16(e_ext * PROD_W'(5)) : '0;
  assign s7 = diffuse ? share16(e_ext * PROD_W'(7)) : '0;

  assign wr_now   = pn_eff + s3;
  assign near_nxt = pf_eff + s5;

  always_comb begin
    if (q < 0) begin
      level = '0;
    end else if (q > Q_W'(255)) begin
      level = '1;
    end else begin
      level = q[LEVEL_W-1:0];
    end
  end

  assign frame_done = pix.last_col && pix.last_row;

  // The pixel on a row's last column has two entries to store; the second goes
  // in the next cycle, when the first pixel of the next row has nothing to write.
  always_comb begin
    if (fire && col_nz) begin
      wr.we   = 1'b1;
      wr.addr = pix.col - COL_W'(1);
      wr.data = wr_now;
    end else begin
      wr.we   = defer_v_r;
      wr.addr = defer_addr_r;
      wr.data = defer_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      right_carry_r <= '0;
      pend_near_r   <= '0;
      pend_far_r    <= '0;
      defer_v_r     <= 1'b0;
    end else begin
      defer_v_r <= fire && pix.last_col;
      if (fire) begin
        if (pix.last_col) begin
          right_carry_r <= '0;
          pend_near_r   <= '0;
          pend_far_r    <= '0;
        end else begin
          right_carry_r <= s7;
          pend_near_r   <= near_nxt;
          pend_far_r    <= s1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && pix.last_col) begin
      defer_addr_r <= pix.col;
      defer_data_r <= near_nxt;
    end
  end

endmodule

FILE: design/error_diffusion_dither_to_byte.sv
// Error-diffusion dither to 8-bit levels with Floyd-Steinberg weights. Pixels
// arrive in raster order as 18-bit signed samples in units of 1/256 of an output
// level; each beat returns one byte, rounded to nearest (ties to even) after the
// diffused error is added, and clipped to 0..255, with frame_done marking the last
// pixel of the frame. The block sustains one pixel per clock while the output is
// not stalled: the error sent to the right is held in a register for the next
// pixel, and the row-below sums live in a 4096-entry line store with one write and
// one read each cycle. A pixel's result passes from the line store read and the
// working stage through the arithmetic into the output register. After reset the
// line store is zeroed by a sweep over its 4096 entries, with in_ready held low;
// the configuration port works throughout. Registers sit at byte addresses 0
// (dither_enable), 4 (line_width) and 8 (row_count) and should only be written
// while no pixel is in flight; a row's end restarts the column, a frame's the row.
module error_diffusion_dither_to_byte (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [edd_pkg::SAMPLE_W-1:0]    in_sample,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [edd_pkg::LEVEL_W-1:0]            out_level,
  output logic                                   out_frame_done,
  input  logic                                   cfg_psel,
  input  logic                                   cfg_penable,
  input  logic                                   cfg_pwrite,
  input  logic [edd_pkg::PADDR_W-1:0]            cfg_paddr,
  input  logic [edd_pkg::PDATA_W-1:0]            cfg_pwdata,
  output logic [edd_pkg::PDATA_W-1:0]            cfg_prdata,
  output logic                                   cfg_pready
);
  import edd_pkg::*;

  cfg_t                    cfg;
  logic                    clearing;
  logic                    accept;
  logic                    fire;

  // Position of the next pixel to be taken.
  logic [COL_W-1:0]        col_r;
  logic [ROW_W-1:0]        row_r;

  // Effective sizes after the out-of-range cases are folded in.
  logic [LWID_W-1:0]       w_eff;
  logic [ROW_W-1:0]        rows_eff;
  logic                    last_col;
  logic                    last_row;

  logic                    stg_v_r;
  pix_t                    stg_r;
  logic signed [ERR_W-1:0] below;
  ls_wr_t                  wr;

  logic                    out_valid_r;
  logic [LEVEL_W-1:0]      out_level_r;
  logic                    out_frame_done_r;
  logic [LEVEL_W-1:0]      level;
  logic                    frame_done;

  edd_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  always_comb begin
    if (cfg.line_width < LWID_W'(2)) begin
      w_eff = LWID_W'(2);
    end else if (cfg.line_width > LWID_W'(MAX_WIDTH)) begin
      w_eff = LWID_W'(MAX_WIDTH);
    end else begin
      w_eff = cfg.line_width;
    end
    rows_eff = (cfg.row_count == '0) ? ROW_W'(1) : cfg.row_count;
  end

  // A column or row at or beyond a shrunk size counts as the last one.
  assign last_col = (LWID_W'(col_r) >= (w_eff - LWID_W'(1)));
  assign last_row = (row_r >= (rows_eff - ROW_W'(1)));

  // The working stage moves on when the output register is free or being emptied,
  // so a byte being taken at the output does not hold back the next input beat.
  assign fire     = stg_v_r && (!out_valid_r || out_ready);
  assign in_ready = !clearing && (!stg_v_r || fire);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : (row_r + ROW_W'(1));
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (accept) begin
      stg_v_r <= 1'b1;
    end else if (fire) begin
      stg_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_r.sample   <= in_sample;
      stg_r.col      <= col_r;
      stg_r.row_nz   <= (row_r != '0);
      stg_r.last_col <= last_col;
      stg_r.last_row <= last_row;
      stg_r.dith     <= cfg.dither_enable;
    end
  end

  // The row-below sum for a pixel is fetched at the beat that takes it in.
  edd_line_store u_ls (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr),
    .rd_en    (accept),
    .rd_addr  (col_r),
    .rd_data  (below),
    .clearing (clearing)
  );

  edd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix        (stg_r),
    .fire       (fire),
    .below      (below),
    .level      (level),
    .frame_done (frame_done),
    .wr         (wr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_level_r      <= level;
      out_frame_done_r <= frame_done;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_level      = out_level_r;
  assign out_frame_done = out_frame_done_r;

endmodule

FILE: bench/error_diffusion_dither_to_byte_tb.sv
module error_diffusion_dither_to_byte_tb;
  import edd_pkg::*;

  // The run is reckoned at roughly fifteen hundred pixels, slowed at worst by heavy
  // idling, plus the line store sweep after reset and the register writes. The
  // limit below is many times that.
  localparam int unsigned CYCLE_LIMIT   = 500000;
  // Settling allowance after the last result is back, before registers change.
  localparam int unsigned SETTLE_CYCLES = 8;
  // Only the first few mismatches are printed, but all of them are counted.
  localparam int unsigned LOG_LIMIT     = 40;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               frame_done;
  } px_result_t;

  // Clock, reset and every input of the block start at known values.
  logic                       clk            = 1'b0;
  logic                       rst_n          = 1'b0;
  logic                       in_valid       = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample      = '0;
  logic                       out_valid;
  logic                       out_ready      = 1'b0;
  logic [LEVEL_W-1:0]         out_level;
  logic                       out_frame_done;
  logic                       cfg_psel       = 1'b0;
  logic                       cfg_penable    = 1'b0;
  logic                       cfg_pwrite     = 1'b0;
  logic [PADDR_W-1:0]         cfg_paddr      = '0;
  logic [PDATA_W-1:0]         cfg_pwdata     = '0;
  logic [PDATA_W-1:0]         cfg_prdata;
  logic                       cfg_pready;

  // Samples waiting to be driven, and the results that accepted pixels must give.
  logic signed [SAMPLE_W-1:0] sample_queue [$];
  px_result_t                 expected_px  [$];

  // The predictor's copy of the registers and of the dithering state.
  logic                       cfg_dith     = 1'b0;
  logic [LWID_W-1:0]          cfg_width    = LINE_WIDTH_RST;
  logic [ROW_W-1:0]           cfg_rows     = ROW_COUNT_RST;
  int                         err_line [MAX_WIDTH];
  int                         carry_right  = 0;
  int                         near_below   = 0;
  int                         far_below    = 0;
  logic [COL_W-1:0]           col_pos      = '0;
  logic [ROW_W-1:0]           row_pos      = '0;

  idle_mode_t                 idle_mode    = IDLE_NONE;
  int unsigned                cycle_count  = 0;
  int unsigned                mismatch_count = 0;
  int unsigned                pixels_queued  = 0;
  int unsigned                pixels_checked = 0;
  int unsigned                frames_seen    = 0;
  int unsigned                reg_writes     = 0;

  error_diffusion_dither_to_byte u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_level      (out_level),
    .out_frame_done (out_frame_done),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // The watchdog: should the block lose or hold back a result, the run ends here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timed out after %0d cycles with %0d results outstanding",
             cycle_count, expected_px.size());
    $display("error_diffusion_dither_to_byte_tb failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < LOG_LIMIT) begin
      $display("Mismatch at cycle %0d: %s", cycle_count, what);
    end
    mismatch_count++;
  endtask

  // One share of the error, k*e/16 at 1/4096 level, with halves going up.
  function automatic int err_share(input int weighted);
    return (weighted + 8) >>> 4;
  endfunction

  // Percentage of cycles in which one side holds back under the current pattern.
  function automatic int unsigned idle_pct(input bit receiver_side);
    case (idle_mode)
      IDLE_SENDER:   return receiver_side ? 0 : 47;
      IDLE_RECEIVER: return receiver_side ? 47 : 0;
      IDLE_BOTH:     return 11;
      default:       return 0;
    endcase
  endfunction

  // Works out the byte for one pixel and moves the error state on, in raster
  // order. Sizes out of range are clamped, and a position left beyond a shrunk
  // size simply ends the row or marks the last row.
  task automatic dither_pixel(input logic signed [SAMPLE_W-1:0] sample,
                              output px_result_t res);
    int  w, rows, col, row, s, inc, x, q, r, e, lvl;
    bit  last_col, last_row, diffuse;
    w    = cfg_width;
    rows = cfg_rows;
    if (w < 2) w = 2;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (rows < 1) rows = 1;
    col      = col_pos;
    row      = row_pos;
    last_col = col >= w - 1;
    last_row = row >= rows - 1;
    if (col == 0) begin
      near_below  = 0;
      far_below   = 0;
      carry_right = 0;
    end
    s   = sample;
    inc = 0;
    if (cfg_dith) begin
      // The line store is only read below the first row, so a new frame starts clean.
      if (row > 0) inc += err_line[col];
      if (col > 0) inc += carry_right;
    end
    x = s * 16 + inc;
    // Round to the nearest level; an exact half goes to the even level.
    q = x >>> 12;
    r = x - q * 4096;
    if (r > 2048 || (r == 2048 && q[0])) q++;
    e = x - q * 4096;
    // Edge columns and the last row take their error in but pass none on.
    diffuse = cfg_dith && !last_row && col > 0 && !last_col;
    if (col > 0) err_line[col - 1] = near_below + (diffuse ? err_share(3 * e) : 0);
    near_below  = far_below + (diffuse ? err_share(5 * e) : 0);
    far_below   = diffuse ? err_share(e) : 0;
    carry_right = diffuse ? err_share(7 * e) : 0;
    // The error above is against the unclipped level; only the byte is clipped.
    lvl = (q < 0) ? 0 : ((q > 255) ? 255 : q);
    res.level      = LEVEL_W'(lvl);
    res.frame_done = last_col && last_row;
    if (last_col) begin
      err_line[col] = near_below;
      near_below    = 0;
      far_below     = 0;
      carry_right   = 0;
      col_pos       = '0;
      row_pos       = last_row ? '0 : ROW_W'(row + 1);
    end else begin
      col_pos = COL_W'(col + 1);
    end
  endtask

  // Mostly ordinary intensities, with a share of exact and near ties, samples
  // below black and above white, and fixed values including the top of the field.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int          v;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      v = $urandom_range(0, 65535);
    end else if (pick < 78) begin
      v = 256 * $urandom_range(0, 255) + 127 + $urandom_range(0, 2);
    end else if (pick < 87) begin
      v = -int'($urandom_range(1, 65536));
    end else if (pick < 96) begin
      v = int'($urandom_range(65536, 131071));
    end else begin
      case ($urandom_range(0, 3))
        0:       v = -65536;
        1:       v = 131071;
        2:       v = -1;
        default: v = 65535;
      endcase
    end
    return SAMPLE_W'(v);
  endfunction

  // The driver presents the next sample once the previous beat has gone, or
  // holds back at random under the sender idling patterns. The predictor runs on
  // each accepted beat, with the registers as they stand for the phase.
  always @(posedge clk) begin
    px_result_t res;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_sample <= '0;
    end else begin
      if (in_valid && in_ready) begin
        dither_pixel(in_sample, res);
        expected_px.push_back(res);
      end
      if (!in_valid || in_ready) begin
        if (sample_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
          in_valid  <= 1'b1;
          in_sample <= sample_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // The monitor compares each result beat with the oldest expectation, field by
  // field, and stalls the result channel at random under the receiver patterns.
  always @(posedge clk) begin
    px_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_px.size() == 0) begin
          report_mismatch($sformatf("result beat level %0d with no pixel outstanding",
                                    out_level));
        end else begin
          want = expected_px.pop_front();
          if (out_level !== want.level) begin
            report_mismatch($sformatf("pixel %0d level %0d, expected %0d",
                                      pixels_checked, out_level, want.level));
          end
          if (out_frame_done !== want.frame_done) begin
            report_mismatch($sformatf("pixel %0d frame_done %b, expected %b",
                                      pixels_checked, out_frame_done, want.frame_done));
          end
          if (want.frame_done) frames_seen++;
          pixels_checked++;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
    end
  end

  // One register write, setup then access, followed by a read of the same
  // register. The predictor takes the new value once the write has landed; this
  // is only ever called with no pixel in flight.
  task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] want;
    logic [PDATA_W-1:0] got;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_DITHER_ENABLE: begin
        cfg_dith = value[0];
        want     = PDATA_W'(cfg_dith);
      end
      REG_LINE_WIDTH: begin
        cfg_width = value[LWID_W-1:0];
        want      = PDATA_W'(cfg_width);
      end
      default: begin
        cfg_rows = value[ROW_W-1:0];
        want     = PDATA_W'(cfg_rows);
      end
    endcase
    if (got !== want) begin
      report_mismatch($sformatf("register %s reads %0d after writing %0d",
                                idx.name(), got, want));
    end
    reg_writes++;
  endtask

  task automatic configure(input bit dith, input int unsigned width, input int unsigned rows);
    write_reg(REG_DITHER_ENABLE, PDATA_W'(dith));
    write_reg(REG_LINE_WIDTH, PDATA_W'(width));
    write_reg(REG_ROW_COUNT, PDATA_W'(rows));
  endtask

  task automatic queue_pixel(input int v);
    sample_queue.push_back(SAMPLE_W'(v));
    pixels_queued++;
  endtask

  // Waits until every queued pixel has come back, then lets the block settle so
  // that the registers can be rewritten safely.
  task automatic wait_idle();
    while (pixels_checked != pixels_queued) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(input idle_mode_t mode, input int unsigned count);
    idle_mode = mode;
    repeat (count) queue_pixel(pick_sample());
    wait_idle();
  endtask

  initial begin
    // Black, the top of the field, -65536, just under white, and ties at half a
    // level on both sides of zero and at the top, where rounding to even decides.
    int          ties_plain [8] = '{0, -65536, 131071, 65535, 128, 384, -128, 65408};
    // Extremes and near-ties once error diffusion is on, so clipping and the
    // unclipped error both show.
    int          ties_dith [10] = '{65535, 131071, -65536, 129, 127, 32767,
                                    -1, 65408, 384, 200};
    int          tiny [4]       = '{300, -300, 65535, 0};
    int unsigned ph;
    int unsigned width;
    int unsigned rows;
    bit          dith;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // The line store sweep after reset holds in_ready low; the driver simply
    // waits for it. Under the reset settings dithering is off, so these pixels
    // only round and clip, and they move the column on to eight.
    idle_mode = IDLE_NONE;
    foreach (ties_plain[i]) queue_pixel(ties_plain[i]);
    wait_idle();

    // A row three wide: the column left at eight is past the new last column,
    // so the first pixel ends its row. Then the rest of that frame and a whole
    // three by two frame with diffusion from the middle column.
    configure(1'b1, 3, 2);
    foreach (ties_dith[i]) queue_pixel(ties_dith[i]);
    wait_idle();

    // A width of one acts as two, and a row count of zero acts as one: every
    // second pixel ends a frame.
    configure(1'b1, 1, 0);
    foreach (tiny[i]) queue_pixel(tiny[i]);
    wait_idle();

    // Random phases walk through settings and idling patterns in turn. One phase
    // runs a longer row over more than a whole frame, so that line store entries
    // far from the start of the row are written and read back.
    for (ph = 0; ph < 16; ph++) begin
      if (ph == 5) begin
        configure(1'b1, 190, 2);
        run_random(IDLE_BOTH, 400);
      end else begin
        dith = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 9))
          0:       width = 2;
          1:       begin
            case ($urandom_range(0, 4))
              0:       width = 0;
              1:       width = 1;
              2:       width = 4097;
              3:       width = 8191;
              default: width = MAX_WIDTH;
            endcase
          end
          2:       width = $urandom_range(13, 80);
          default: width = $urandom_range(2, 12);
        endcase
        case ($urandom_range(0, 7))
          0:       rows = 1;
          1:       rows = 0;
          2:       rows = 65535;
          default: rows = $urandom_range(2, 6);
        endcase
        configure(dith, width, rows);
        run_random(idle_mode_t'(ph % 4), $urandom_range(40, 100));
      end
    end

    // Finally plain rounding again on a small frame, with no idling at all.
    configure(1'b0, 4, 3);
    run_random(IDLE_NONE, 60);

    if (expected_px.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_px.size()));
    end
    $display("Checked %0d pixels and %0d whole frames over %0d register writes,",
             pixels_checked, frames_seen, reg_writes);
    $display("with dithering on and off, clamped sizes and four idling patterns.");
    if (mismatch_count == 0) begin
      $display("error_diffusion_dither_to_byte_tb passed");
    end else begin
      $display("error_diffusion_dither_to_byte_tb failed");
    end
    $finish;
  end

endmodule
